### rtl/u8sv_pkg.sv
// ----------------------------------------------------------------------------
// u8sv_pkg: shared types and constants of the UTF-8 stream validator
// Byte classes, the step request between classifier and tracker, the
// result payload and the position width.
// ----------------------------------------------------------------------------
package u8sv_pkg;

	localparam int INDEX_WIDTH = 16;
	localparam logic [INDEX_WIDTH-1:0] IDX_MAX = {INDEX_WIDTH{1'b1}};

	typedef logic [INDEX_WIDTH-1:0] idx_t;

	typedef enum logic [2:0] {
		CLS_ASCII = 3'd0,
		CLS_CONT  = 3'd1,
		CLS_LEAD2 = 3'd2,
		CLS_LEAD3 = 3'd3,
		CLS_LEAD4 = 3'd4,
		CLS_BAD   = 3'd5
	} byte_cls_t;

	typedef struct packed {
		byte_cls_t cls;
		logic      last;
	} step_t;

	typedef struct packed {
		logic valid_res;
		idx_t error_index;
	} result_t;

endpackage

### rtl/u8sv_if.sv
// ----------------------------------------------------------------------------
// u8sv_if: request and result channels of the UTF-8 stream validator
// Valid/ready channels; a request moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface u8sv_req_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8sv_rsp_if
	import u8sv_pkg::*;
();
	logic valid;
	logic ready;
	logic valid_res;
	idx_t error_index;

	modport source (output valid, output valid_res, output error_index, input ready);
	modport sink (input valid, input valid_res, input error_index, output ready);
endinterface

### rtl/utf8_stream_validator_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator_core: streaming UTF-8 form checker
// Flow: an accepted byte is held in the input register and tracked as it moves
// on; a last byte loads its verdict into the result register, which offers it.
// Throughput: one byte per cycle; the result register lets the next byte in
// while a verdict waits, and only a last byte facing a full result stalls.
// Reset: arst_n clears all position, sequence and error state at once.
// ----------------------------------------------------------------------------
module utf8_stream_validator_core
	import u8sv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	u8sv_req_if.sink   req,
	u8sv_rsp_if.source rsp
);

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       last_s1;
	byte_cls_t  cls;
	step_t      step;
	result_t    res;
	logic       res_valid_q;
	result_t    res_q;
	logic       res_free;
	logic       adv_s1;

	assign res_free  = !res_valid_q || rsp.ready;
	assign adv_s1    = valid_s1 && (!last_s1 || res_free);
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			data_byte_s1 <= req.data_byte;
			last_s1      <= req.last_byte;
		end
	end

	u8sv_classify u_classify (
		.data_byte (data_byte_s1),
		.cls       (cls)
	);

	assign step.cls  = cls;
	assign step.last = last_s1;

	u8sv_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (adv_s1),
		.step    (step),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= adv_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && adv_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign rsp.valid       = res_valid_q;
	assign rsp.valid_res   = res_q.valid_res;
	assign rsp.error_index = res_q.error_index;

endmodule

### rtl/u8sv_classify.sv
// ----------------------------------------------------------------------------
// u8sv_classify: byte class decoder
// Sorts a raw byte into single, follower, 2/3/4-byte lead or illegal.
// ----------------------------------------------------------------------------
module u8sv_classify
	import u8sv_pkg::*;
(
	input  logic [7:0] data_byte,
	output byte_cls_t  cls
);

	always_comb begin
		unique case (data_byte) inside
			[8'd0:8'd127]:   cls = CLS_ASCII;
			[8'd128:8'd191]: cls = CLS_CONT;
			[8'd192:8'd223]: cls = CLS_LEAD2;
			[8'd224:8'd239]: cls = CLS_LEAD3;
			[8'd240:8'd247]: cls = CLS_LEAD4;
			default:         cls = CLS_BAD;
		endcase
	end

endmodule

### rtl/u8sv_tracker.sv
// ----------------------------------------------------------------------------
// u8sv_tracker: sequence state and first-error tracking
// Advances the open-sequence state by one classified byte per step and
// forms the verdict on the last byte of a string.
// ----------------------------------------------------------------------------
module u8sv_tracker
	import u8sv_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step_en,
	input  step_t   step,
	output result_t result
);

	logic [1:0] bytes_pending_q, pend_n;
	idx_t       sequence_start_q, seq_n;
	idx_t       byte_position_q, pos_n;
	logic       error_seen_q, err_n;
	idx_t       error_position_q, errpos_n;

	always_comb begin
		pend_n   = bytes_pending_q;
		seq_n    = sequence_start_q;
		err_n    = error_seen_q;
		errpos_n = error_position_q;
		if (!error_seen_q) begin
			if (bytes_pending_q != 2'd0) begin
				if (step.cls == CLS_CONT) begin
					pend_n = bytes_pending_q - 2'd1;
				end else begin
					err_n    = 1'b1;
					errpos_n = sequence_start_q;
					pend_n   = 2'd0;
				end
			end else begin
				case (step.cls)
					CLS_ASCII: ;
					CLS_LEAD2: begin
						pend_n = 2'd1;
						seq_n  = byte_position_q;
					end
					CLS_LEAD3: begin
						pend_n = 2'd2;
						seq_n  = byte_position_q;
					end
					CLS_LEAD4: begin
						pend_n = 2'd3;
						seq_n  = byte_position_q;
					end
					default: begin
						err_n    = 1'b1;
						errpos_n = byte_position_q;
					end
				endcase
			end
			if (step.last && !err_n && pend_n != 2'd0) begin
				err_n    = 1'b1;
				errpos_n = seq_n;
				pend_n   = 2'd0;
			end
		end
		pos_n = (byte_position_q == IDX_MAX) ? IDX_MAX : byte_position_q + idx_t'(1);
	end

	assign result.valid_res   = !err_n;
	assign result.error_index = err_n ? errpos_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_pending_q  <= '0;
			sequence_start_q <= '0;
			byte_position_q  <= '0;
			error_seen_q     <= 1'b0;
			error_position_q <= '0;
		end else if (step_en) begin
			if (step.last) begin
				bytes_pending_q  <= '0;
				sequence_start_q <= '0;
				byte_position_q  <= '0;
				error_seen_q     <= 1'b0;
				error_position_q <= '0;
			end else begin
				bytes_pending_q  <= pend_n;
				sequence_start_q <= seq_n;
				byte_position_q  <= pos_n;
				error_seen_q     <= err_n;
				error_position_q <= errpos_n;
			end
		end
	end

	a_pend_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_pending_q != 2'd0 |-> !error_seen_q)
		else $error("sequence still open after an error");

	a_seq_behind: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_pending_q != 2'd0 |-> sequence_start_q <= byte_position_q)
		else $error("open sequence starts after current byte");

	a_err_behind: assert property (@(posedge clk) disable iff (!arst_n)
		error_seen_q |-> error_position_q <= byte_position_q)
		else $error("error placed beyond current byte");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && step.last |=> byte_position_q == '0 && !error_seen_q)
		else $error("state not cleared after last byte");

endmodule

### tb/sv/utf8_stream_validator_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_validator_core_tb: self-checking bench of the UTF-8 validator
// Streams byte strings into the request channel and tracks every accepted
// byte in a local scanner that builds the expected verdict of each string.
// Verdicts from the result channel are compared in order against it. Covers
// byte-class extremes, bad and stray bytes, cut-off sequences, mostly
// well-formed random text under several idle and stall mixes, and result
// backpressure that stalls the input.
// ----------------------------------------------------------------------------
module utf8_stream_validator_core_tb;
	import u8sv_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_CYCLES = 8;

	typedef logic [7:0] byte_q_t[$];

	logic clk;
	logic arst_n;

	u8sv_req_if req();
	u8sv_rsp_if rsp();

	utf8_stream_validator_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	logic [1:0] follow_left;
	idx_t       seq_lead_pos;
	idx_t       cur_pos;
	logic       err_flag;
	idx_t       err_pos;
	result_t    verdict_q[$];

	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int mismatches;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic void note_error(input idx_t where);
		err_flag = 1'b1;
		err_pos = where;
		follow_left = 2'd0;
	endfunction

	function automatic void scan_byte(input logic [7:0] b, input logic l);
		byte_cls_t cls;
		idx_t      p;
		result_t   r;
		p = cur_pos;
		if (b <= 8'd127)
			cls = CLS_ASCII;
		else if (b <= 8'd191)
			cls = CLS_CONT;
		else if (b <= 8'd223)
			cls = CLS_LEAD2;
		else if (b <= 8'd239)
			cls = CLS_LEAD3;
		else if (b <= 8'd247)
			cls = CLS_LEAD4;
		else
			cls = CLS_BAD;
		if (!err_flag) begin
			if (follow_left != 2'd0) begin
				if (cls == CLS_CONT)
					follow_left = follow_left - 2'd1;
				else
					note_error(seq_lead_pos);
			end else begin
				case (cls)
					CLS_ASCII: ;
					CLS_LEAD2: begin
						follow_left = 2'd1;
						seq_lead_pos = p;
					end
					CLS_LEAD3: begin
						follow_left = 2'd2;
						seq_lead_pos = p;
					end
					CLS_LEAD4: begin
						follow_left = 2'd3;
						seq_lead_pos = p;
					end
					default: note_error(p);
				endcase
			end
			if (l && !err_flag && follow_left != 2'd0)
				note_error(seq_lead_pos);
		end
		if (p != IDX_MAX)
			cur_pos = p + 1'b1;
		if (l) begin
			r.valid_res = !err_flag;
			r.error_index = err_flag ? err_pos : '0;
			verdict_q.push_back(r);
			follow_left = 2'd0;
			seq_lead_pos = '0;
			cur_pos = '0;
			err_flag = 1'b0;
			err_pos = '0;
		end
	endfunction

	// Hold each request until accepted; return on the following falling edge.
	task automatic send_byte(input logic [7:0] b, input logic l);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.data_byte <= b;
		req.last_byte <= l;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		scan_byte(b, l);
		@(negedge clk);
	endtask

	task automatic send_text(input byte_q_t text);
		foreach (text[i])
			send_byte(text[i], i == text.size() - 1);
	endtask

	task automatic send_packed(input logic [95:0] bytes, input int n);
		byte_q_t text;
		for (int i = 0; i < n; i++)
			text.push_back(bytes[8*(n-1-i) +: 8]);
		send_text(text);
	endtask

	task automatic wait_verdicts();
		req.valid <= 1'b0;
		@(negedge clk);
		while (verdict_q.size() != 0)
			@(negedge clk);
	endtask

	function automatic byte_q_t make_text();
		byte_q_t text;
		int      at;
		repeat ($urandom_range(1, 8)) begin
			case ($urandom_range(0, 3))
				0: text.push_back(8'($urandom_range(0, 127)));
				1: begin
					text.push_back(8'($urandom_range(192, 223)));
					text.push_back(8'($urandom_range(128, 191)));
				end
				2: begin
					text.push_back(8'($urandom_range(224, 239)));
					repeat (2) text.push_back(8'($urandom_range(128, 191)));
				end
				default: begin
					text.push_back(8'($urandom_range(240, 247)));
					repeat (3) text.push_back(8'($urandom_range(128, 191)));
				end
			endcase
		end
		if ($urandom_range(0, 99) < 30) begin
			at = $urandom_range(0, text.size() - 1);
			case ($urandom_range(0, 3))
				0: text[at] = 8'($urandom_range(0, 255));
				1: if (text.size() > 1) text.pop_back();
				2: text.insert(at, 8'($urandom_range(128, 191)));
				default: text.insert(at, 8'($urandom_range(248, 255)));
			endcase
		end
		return text;
	endfunction

	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_packed({8'h7F, 8'hC0, 8'h80, 8'hEF, 8'hBF, 8'hBF,
			8'hF7, 8'h80, 8'hBF, 8'h80}, 10);
		send_packed({8'hDF, 8'h7F}, 2);
		send_packed({8'h00, 8'hF8, 8'hE0}, 3);
		send_packed({8'h41, 8'h80}, 2);
		send_packed({8'hE0, 8'h80}, 2);
		send_packed({8'h20, 8'hF0}, 2);
		send_packed({8'hFF}, 1);
		wait_verdicts();
	endtask

	task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
		byte_q_t text;
		int      sent;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			text = make_text();
			send_text(text);
			sent += text.size();
		end
		wait_verdicts();
	endtask

	// Hold off results long enough for the core to back up into its input.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 300;
		repeat (40)
			send_byte(8'($urandom_range(0, 255)), 1'b1);
		wait_verdicts();
	endtask

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				rsp.ready <= 1'b0;
				hold_left--;
			end else begin
				rsp.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_verdict
		result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (verdict_q.size() == 0) begin
				$error("unexpected verdict: valid_res %0d, error_index %0d",
					rsp.valid_res, rsp.error_index);
				mismatches++;
			end else begin
				want = verdict_q.pop_front();
				if (rsp.valid_res !== want.valid_res) begin
					$error("valid_res: expected %0d, got %0d", want.valid_res, rsp.valid_res);
					mismatches++;
				end
				if (rsp.error_index !== want.error_index) begin
					$error("error_index: expected %0d, got %0d",
						want.error_index, rsp.error_index);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data_byte = 8'd0;
		req.last_byte = 1'b0;
		follow_left = 2'd0;
		seq_lead_pos = '0;
		cur_pos = '0;
		err_flag = 1'b0;
		err_pos = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		mismatches = 0;
		cycle_count = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(350, 0, 0);
		test_random(350, 64, 0);
		test_random(350, 0, 64);
		test_random(350, 16, 16);
		test_backpressure();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && verdict_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### sim.f
rtl/u8sv_pkg.sv
rtl/u8sv_if.sv
rtl/u8sv_classify.sv
rtl/u8sv_tracker.sv
rtl/utf8_stream_validator_core.sv
tb/sv/utf8_stream_validator_core_tb.sv
